// ===== sv/i2c_master_byte_engine_core_defines.svh =====
// assertion macros for the i2c master byte engine checker
// no dependencies; included by the assertion file only
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define I2CM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/i2cm_pkg.sv =====
// shared types and constants for the i2c master byte engine
// no dependencies; used by i2cm_tick and the top level
`default_nettype none

package i2cm_pkg;

  // command codes carried on the opcode field
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_START     = 3'd1,
    OP_ADDR      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_READ_ACK  = 3'd4,
    OP_READ_NACK = 3'd5,
    OP_STOP      = 3'd6
  } op_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS      = 1'd1;
  localparam logic [7:0]           TICKS_RESET    = 8'd4;

  // bit slot index of the ack slot and msb mask of the shift byte
  localparam logic [3:0] BIT_ACK   = 4'd8;
  localparam logic [7:0] SHIFT_MSB = 8'h80;

  // last phase of a bit slot or of start/stop
  localparam logic [1:0] PHASE_LAST = 2'd3;

  // engine state, line drives are {scl, sda}
  typedef struct packed {
    op_e        kind;
    logic [1:0] phase;
    logic [7:0] tick;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic [1:0] drives;
    logic       nack;
  } state_t;

  localparam state_t STATE_RESET = '{
    kind:    OP_NONE,
    phase:   2'd0,
    tick:    8'd0,
    bit_cnt: 4'd0,
    shift:   8'd0,
    drives:  2'd0,
    nack:    1'b0
  };

endpackage

`default_nettype wire

// ===== sv/i2cm_tick.sv =====
// next-state logic for one bus tick of the i2c master byte engine
// depends on i2cm_pkg
`default_nettype none

module i2cm_tick (
  input  var i2cm_pkg::state_t cur_i,
  input  wire logic [6:0]      slave_addr_i,
  input  wire logic [7:0]      ticks_per_phase_i,
  input  wire logic [2:0]      opcode_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            read_not_write_i,
  input  wire logic            sda_level_i,
  output i2cm_pkg::state_t     nxt_o,
  output logic                 done_o
);

  // line pattern for a phase, {scl, sda}
  function automatic logic [1:0] drives_f(i2cm_pkg::op_e kind, logic [1:0] ph,
                                          logic [3:0] bit_cnt, logic [7:0] shift);
    logic scl;
    logic sda;
    scl = (ph == 2'd0) || (ph == i2cm_pkg::PHASE_LAST);
    sda = 1'b0;
    if (kind == i2cm_pkg::OP_START) begin
      return (ph < 2'd2) ? 2'b01 : 2'b11;
    end
    if (kind == i2cm_pkg::OP_STOP) begin
      if (ph == 2'd0) return 2'b11;
      if (ph == 2'd1) return 2'b01;
      return 2'b00;
    end
    if (kind == i2cm_pkg::OP_ADDR || kind == i2cm_pkg::OP_WRITE) begin
      sda = (bit_cnt < i2cm_pkg::BIT_ACK) && ((shift & i2cm_pkg::SHIFT_MSB) == 8'd0);
    end else begin
      sda = (bit_cnt == i2cm_pkg::BIT_ACK) && (kind == i2cm_pkg::OP_READ_ACK);
    end
    return {scl, sda};
  endfunction

  i2cm_pkg::state_t s;
  logic             sending;
  logic             phase_end;
  logic             cmd_valid;

  always_comb begin
    s         = cur_i;
    done_o    = 1'b0;
    sending   = 1'b0;
    phase_end = 1'b0;
    cmd_valid = (opcode_i >= i2cm_pkg::OP_START) && (opcode_i <= i2cm_pkg::OP_STOP);

    // take a new command when idle
    if (cur_i.kind == i2cm_pkg::OP_NONE && cmd_valid) begin
      s.kind    = i2cm_pkg::op_e'(opcode_i);
      s.phase   = 2'd0;
      s.tick    = 8'd0;
      s.bit_cnt = 4'd0;
      s.nack    = 1'b0;
      case (s.kind)
        i2cm_pkg::OP_ADDR:      s.shift = {slave_addr_i, read_not_write_i};
        i2cm_pkg::OP_WRITE:     s.shift = data_byte_i;
        i2cm_pkg::OP_READ_ACK,
        i2cm_pkg::OP_READ_NACK: s.shift = 8'd0;
        default:                s.shift = cur_i.shift;
      endcase
    end

    // advance the active command by one tick
    if (s.kind != i2cm_pkg::OP_NONE) begin
      sending   = (s.kind == i2cm_pkg::OP_ADDR) || (s.kind == i2cm_pkg::OP_WRITE);
      s.drives  = drives_f(s.kind, s.phase, s.bit_cnt, s.shift);
      phase_end = !(({1'b0, s.tick} + 9'd1) < {1'b0, ticks_per_phase_i});
      if (!phase_end) begin
        s.tick = s.tick + 8'd1;
      end else begin
        s.tick = 8'd0;
        if (s.kind == i2cm_pkg::OP_START || s.kind == i2cm_pkg::OP_STOP) begin
          if (s.phase == i2cm_pkg::PHASE_LAST) begin
            s.drives = (s.kind == i2cm_pkg::OP_START) ? 2'b11 : 2'b00;
            s.kind   = i2cm_pkg::OP_NONE;
            done_o   = 1'b1;
          end else begin
            s.phase = s.phase + 2'd1;
          end
        end else if (s.phase == 2'd1 && s.bit_cnt == i2cm_pkg::BIT_ACK && sending &&
                     sda_level_i) begin
          // slave did not acknowledge: release both lines, no stop
          s.drives = 2'b00;
          s.nack   = 1'b1;
          s.kind   = i2cm_pkg::OP_NONE;
          done_o   = 1'b1;
        end else begin
          // sample a read bit at the end of the first scl-high phase
          if (s.phase == 2'd1 && s.bit_cnt < i2cm_pkg::BIT_ACK && !sending) begin
            s.shift = {s.shift[6:0], sda_level_i};
          end
          if (s.phase == i2cm_pkg::PHASE_LAST) begin
            if (sending && s.bit_cnt < i2cm_pkg::BIT_ACK) begin
              s.shift = {s.shift[6:0], 1'b0};
            end
            if (s.bit_cnt >= i2cm_pkg::BIT_ACK) begin
              s.drives = 2'b10;
              s.kind   = i2cm_pkg::OP_NONE;
              done_o   = 1'b1;
            end else begin
              s.bit_cnt = s.bit_cnt + 4'd1;
              s.phase   = 2'd0;
            end
          end else begin
            s.phase = s.phase + 2'd1;
          end
        end
      end
    end

    nxt_o = s;
  end

endmodule

`default_nettype wire

// ===== sv/i2c_master_byte_engine_core.sv =====
// i2c master byte engine, top level: config registers, state and result register
// depends on i2cm_pkg and i2cm_tick
//
// usage:
//   every input item is one bus tick from an external prescaler. it carries the
//   sampled sda level and, while the engine is idle, a command opcode with its
//   data byte or direction bit. unrecognized opcodes and commands issued while
//   busy are ignored.
//   every accepted item yields exactly one result item: the scl/sda pull-low
//   drives, busy, a one-item command-done pulse, the nack flag and the shift byte.
//   the result is registered and appears on the cycle after acceptance.
//   throughput is one item per cycle unless stalled; the tick update is a single
//   pass of logic from the state register into the state and result registers.
//   when the receiver stalls, the result register holds its item and the
//   input side stalls only if that register is full and not being taken.
//   reset clears the config to address 0 and 4 ticks per phase, idles the
//   engine with both lines released and empties the result register.
//   config writes are taken on any cycle with cfg_we_i high; write them only
//   while the engine is idle.
`default_nettype none

module i2c_master_byte_engine_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]                    cfg_wdata_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [2:0]                    opcode_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          read_not_write_i,
  input  wire logic                          sda_level_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               scl_pull_low_o,
  output logic                               sda_pull_low_o,
  output logic                               busy_res_o,
  output logic                               command_done_o,
  output logic                               nack_seen_o,
  output logic [7:0]                         received_byte_o
);

  logic [6:0]       slave_addr_q;
  logic [7:0]       ticks_q;
  i2cm_pkg::state_t state_q;
  i2cm_pkg::state_t state_d;
  logic             done_d;
  logic             in_acc;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             scl_q;
  logic             sda_q;
  logic             busy_q;
  logic             done_q;
  logic             nack_q;
  logic [7:0]       rx_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 7'd0;
      ticks_q      <= i2cm_pkg::TICKS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == i2cm_pkg::CFG_SLAVE_ADDR) slave_addr_q <= cfg_wdata_i[6:0];
      if (cfg_idx_i == i2cm_pkg::CFG_TICKS)      ticks_q      <= cfg_wdata_i;
    end
  end

  // handshake: accept whenever the result register is free or draining
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_d = in_acc || (out_valid_q && out_stall_i);

  // per-tick next state
  i2cm_tick u_tick (
    .cur_i             (state_q),
    .slave_addr_i      (slave_addr_q),
    .ticks_per_phase_i (ticks_q),
    .opcode_i          (opcode_i),
    .data_byte_i       (data_byte_i),
    .read_not_write_i  (read_not_write_i),
    .sda_level_i       (sda_level_i),
    .nxt_o             (state_d),
    .done_o            (done_d)
  );

  // engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2cm_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) state_q <= state_d;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scl_q  <= state_d.drives[1];
      sda_q  <= state_d.drives[0];
      busy_q <= (state_d.kind != i2cm_pkg::OP_NONE);
      done_q <= done_d;
      nack_q <= state_d.nack;
      rx_q   <= state_d.shift;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_pull_low_o  = scl_q;
  assign sda_pull_low_o  = sda_q;
  assign busy_res_o      = busy_q;
  assign command_done_o  = done_q;
  assign nack_seen_o     = nack_q;
  assign received_byte_o = rx_q;

endmodule

`default_nettype wire

// ===== sv/i2cm_checker.sv =====
// port-level checks for the i2c master byte engine, bound to the top level
// depends on i2c_master_byte_engine_core_defines.svh
`default_nettype none
`include "i2c_master_byte_engine_core_defines.svh"

module i2cm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic scl_pull_low_o,
  input wire logic sda_pull_low_o,
  input wire logic busy_res_o,
  input wire logic command_done_o,
  input wire logic nack_seen_o
);

  // a stalled result item stays offered
  `I2CM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result item dropped under stall")

  // a finished command leaves the engine idle
  `I2CM_ASSERT(a_done_idle, clk_i, rst_ni, out_valid_o && command_done_o |-> !busy_res_o, "done while busy")

  // a nack ends with both lines released
  `I2CM_ASSERT(a_nack_release, clk_i, rst_ni, out_valid_o && command_done_o && nack_seen_o |-> !scl_pull_low_o && !sda_pull_low_o, "lines held after nack")

  // input is never stalled while the result register is empty
  `I2CM_ASSERT_ALWAYS(a_no_idle_stall, clk_i, !out_valid_o |-> !in_stall_o, "stall with empty result register")

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_i2cm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .scl_pull_low_o (scl_pull_low_o),
  .sda_pull_low_o (sda_pull_low_o),
  .busy_res_o     (busy_res_o),
  .command_done_o (command_done_o),
  .nack_seen_o    (nack_seen_o)
);

`default_nettype wire

// ===== verif/i2c_master_byte_engine_core_tb.sv =====
`timescale 1ns / 100ps
// testbench for the i2c master byte engine: bus ticks with commands go in,
// one line/status item per tick comes out and is checked against a tick predictor
// depends on i2cm_pkg and i2c_master_byte_engine_core

// one result item: line drives and status after a tick
typedef struct packed {
  logic       scl_low;
  logic       sda_low;
  logic       busy;
  logic       done;
  logic       nack;
  logic [7:0] rx_byte;
} bus_lines_t;

// tick-level predictor of the engine plus the queue of expected line states
class i2c_tick_scoreboard;
  logic [6:0]    slave_addr;
  logic [7:0]    phase_ticks;
  i2cm_pkg::op_e kind;
  logic [1:0]    ph_idx;
  logic [7:0]    tick_cnt;
  logic [3:0]    bit_idx;
  logic [7:0]    shift_reg;
  logic [1:0]    drives;
  logic          nack;
  bus_lines_t    expected_q[$];
  int            mismatches;
  int            checked;
  int            commands;
  int            nacks;

  function new();
    slave_addr  = 7'd0;
    phase_ticks = i2cm_pkg::TICKS_RESET;
    kind        = i2cm_pkg::OP_NONE;
    ph_idx      = 2'd0;
    tick_cnt    = 8'd0;
    bit_idx     = 4'd0;
    shift_reg   = 8'd0;
    drives      = 2'b00;
    nack        = 1'b0;
    mismatches  = 0;
    checked     = 0;
    commands    = 0;
    nacks       = 0;
  endfunction

  function void write_reg(logic [i2cm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    if (idx == i2cm_pkg::CFG_SLAVE_ADDR) slave_addr = val[6:0];
    else if (idx == i2cm_pkg::CFG_TICKS) phase_ticks = val;
  endfunction

  function bit busy();
    return kind != i2cm_pkg::OP_NONE;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // {scl, sda} pull-low pattern for the current phase
  function logic [1:0] phase_drives();
    logic scl_low;
    logic sda_low;
    case (kind)
      i2cm_pkg::OP_START: return (ph_idx < 2'd2) ? 2'b01 : 2'b11;
      i2cm_pkg::OP_STOP:  return (ph_idx == 2'd0) ? 2'b11 : (ph_idx == 2'd1) ? 2'b01 : 2'b00;
      default: begin
        scl_low = (ph_idx == 2'd0 || ph_idx == i2cm_pkg::PHASE_LAST);
        if (kind == i2cm_pkg::OP_ADDR || kind == i2cm_pkg::OP_WRITE)
          sda_low = (bit_idx < i2cm_pkg::BIT_ACK) &&
                    ((shift_reg & i2cm_pkg::SHIFT_MSB) == 8'd0);
        else
          sda_low = (bit_idx == i2cm_pkg::BIT_ACK) && (kind == i2cm_pkg::OP_READ_ACK);
        return {scl_low, sda_low};
      end
    endcase
  endfunction

  // advance the engine by one accepted tick and queue the line state it yields
  function void note_tick(logic [2:0] op, logic [7:0] data, logic rnw, logic sda);
    logic       done;
    logic       sending;
    bus_lines_t item;
    done = 1'b0;
    // accept a command only while idle
    if (kind == i2cm_pkg::OP_NONE && op >= i2cm_pkg::OP_START && op <= i2cm_pkg::OP_STOP)
    begin
      kind     = i2cm_pkg::op_e'(op);
      ph_idx   = 2'd0;
      tick_cnt = 8'd0;
      bit_idx  = 4'd0;
      nack     = 1'b0;
      commands++;
      case (kind)
        i2cm_pkg::OP_ADDR:  shift_reg = {slave_addr, rnw};
        i2cm_pkg::OP_WRITE: shift_reg = data;
        i2cm_pkg::OP_READ_ACK, i2cm_pkg::OP_READ_NACK: shift_reg = 8'd0;
        default: ;
      endcase
    end
    if (kind != i2cm_pkg::OP_NONE) begin
      sending = (kind == i2cm_pkg::OP_ADDR || kind == i2cm_pkg::OP_WRITE);
      drives  = phase_drives();
      // a zero phase length behaves like one tick
      if ({1'b0, tick_cnt} + 9'd1 < {1'b0, phase_ticks}) begin
        tick_cnt++;
      end else begin
        tick_cnt = 8'd0;
        if (kind == i2cm_pkg::OP_START || kind == i2cm_pkg::OP_STOP) begin
          if (ph_idx == i2cm_pkg::PHASE_LAST) begin
            drives = (kind == i2cm_pkg::OP_START) ? 2'b11 : 2'b00;
            kind   = i2cm_pkg::OP_NONE;
            done   = 1'b1;
          end else begin
            ph_idx++;
          end
        end else if (ph_idx == 2'd1 && bit_idx == i2cm_pkg::BIT_ACK && sending && sda) begin
          // slave did not acknowledge: release both lines, no stop
          drives = 2'b00;
          nack   = 1'b1;
          kind   = i2cm_pkg::OP_NONE;
          done   = 1'b1;
          nacks++;
        end else begin
          if (ph_idx == 2'd1 && bit_idx < i2cm_pkg::BIT_ACK && !sending)
            shift_reg = {shift_reg[6:0], sda};
          if (ph_idx == i2cm_pkg::PHASE_LAST) begin
            if (sending && bit_idx < i2cm_pkg::BIT_ACK) shift_reg = {shift_reg[6:0], 1'b0};
            if (bit_idx >= i2cm_pkg::BIT_ACK) begin
              drives = 2'b10;
              kind   = i2cm_pkg::OP_NONE;
              done   = 1'b1;
            end else begin
              bit_idx++;
              ph_idx = 2'd0;
            end
          end else begin
            ph_idx++;
          end
        end
      end
    end
    item = '{drives[1], drives[0], kind != i2cm_pkg::OP_NONE, done, nack, shift_reg};
    expected_q.push_back(item);
  endfunction

  task report(string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
  endtask

  task check_lines(bus_lines_t got);
    bus_lines_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with no tick outstanding", checked));
      return;
    end
    want = expected_q.pop_front();
    compare_field("scl_pull_low", 8'(got.scl_low), 8'(want.scl_low));
    compare_field("sda_pull_low", 8'(got.sda_low), 8'(want.sda_low));
    compare_field("busy_res", 8'(got.busy), 8'(want.busy));
    compare_field("command_done", 8'(got.done), 8'(want.done));
    compare_field("nack_seen", 8'(got.nack), 8'(want.nack));
    compare_field("received_byte", got.rx_byte, want.rx_byte);
    checked++;
  endtask
endclass

module i2c_master_byte_engine_core_tb;

  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0]  OP_UNUSED   = 3'd7;

  // how the sampled sda level behaves during a command
  typedef enum {SDA_LOW, SDA_HIGH, SDA_NOISY} sda_plan_e;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]                     cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [2:0]                     opcode;
  logic [7:0]                     data_byte;
  logic                           rnw;
  logic                           sda_level;
  logic                           out_valid;
  logic                           out_stall;
  logic                           scl_low;
  logic                           sda_low;
  logic                           busy;
  logic                           cmd_done;
  logic                           nack_seen;
  logic [7:0]                     rx_byte;

  i2c_tick_scoreboard   scoreboard;
  int                   work_ticks;
  int                   cycle_cnt = 0;
  bit                   idle_off;

  i2c_master_byte_engine_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .data_byte_i      (data_byte),
    .read_not_write_i (rnw),
    .sda_level_i      (sda_level),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .scl_pull_low_o   (scl_low),
    .sda_pull_low_o   (sda_low),
    .busy_res_o       (busy),
    .command_done_o   (cmd_done),
    .nack_seen_o      (nack_seen),
    .received_byte_o  (rx_byte)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      scoreboard.check_lines('{scl_low, sda_low, busy, cmd_done, nack_seen, rx_byte});
  end

  // receiver stall bursts, with free-running stretches between them
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (idle_off) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic pick_sda(sda_plan_e plan);
    case (plan)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // mostly acknowledged, sometimes not
  function automatic sda_plan_e ack_plan();
    return ($urandom_range(0, 9) == 0) ? SDA_HIGH : SDA_LOW;
  endfunction

  // drive one tick item, wait until it is taken, then feed the predictor
  task automatic send_tick(logic [2:0] op, logic [7:0] data, logic dir, logic sda);
    if (!idle_off && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    data_byte <= data;
    rnw       <= dir;
    sda_level <= sda;
    do @(posedge clk); while (in_stall);
    scoreboard.note_tick(op, data, dir, sda);
  endtask

  // ticks while idle that carry no command
  task automatic idle_ticks(int n);
    for (int i = 0; i < n; i++)
      send_tick((i % 2) ? OP_UNUSED : i2cm_pkg::OP_NONE, 8'($urandom), 1'($urandom),
                1'($urandom));
  endtask

  // issue a command on an idle tick and tick until it ends; stray opcodes while busy
  task automatic run_command(i2cm_pkg::op_e op, logic [7:0] data, logic dir,
                             sda_plan_e plan, int noise_pct);
    logic [2:0] stray;
    send_tick(op, data, dir, pick_sda(plan));
    work_ticks++;
    while (scoreboard.busy()) begin
      stray = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) :
                                                    i2cm_pkg::OP_NONE;
      send_tick(stray, 8'($urandom), 1'($urandom), pick_sda(plan));
      work_ticks++;
    end
  endtask

  // finish the running command and wait until every result has come back
  task automatic settle();
    while (scoreboard.busy()) send_tick(i2cm_pkg::OP_NONE, 8'd0, 1'b0, 1'($urandom));
    in_valid <= 1'b0;
    while (scoreboard.pending() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [i2cm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scoreboard.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(logic [7:0] addr, logic [7:0] ticks);
    write_reg(i2cm_pkg::CFG_SLAVE_ADDR, addr);
    write_reg(i2cm_pkg::CFG_TICKS, ticks);
  endtask

  // mostly a well-formed transfer, sometimes a lone command or idle ticks
  task automatic random_transaction();
    int   n_bytes;
    logic dir;
    if ($urandom_range(0, 4) == 0) begin
      if ($urandom_range(0, 1)) idle_ticks($urandom_range(1, 6));
      else run_command(i2cm_pkg::op_e'($urandom_range(1, 6)), 8'($urandom), 1'($urandom),
                       SDA_NOISY, 10);
      return;
    end
    dir = 1'($urandom);
    run_command(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_NOISY, 5);
    run_command(i2cm_pkg::OP_ADDR, 8'($urandom), dir, ack_plan(), 5);
    n_bytes = $urandom_range(0, 3);
    for (int i = 0; i < n_bytes && !scoreboard.nack; i++) begin
      if (dir)
        run_command((i == n_bytes - 1) ? i2cm_pkg::OP_READ_NACK : i2cm_pkg::OP_READ_ACK,
                    8'($urandom), 1'($urandom), SDA_NOISY, 5);
      else
        run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom), ack_plan(), 5);
    end
    if (!scoreboard.nack || $urandom_range(0, 1))
      run_command(i2cm_pkg::OP_STOP, 8'($urandom), 1'($urandom), SDA_NOISY, 5);
  endtask

  task automatic run_phase(int budget);
    int start_ticks;
    start_ticks = work_ticks;
    while (work_ticks - start_ticks < budget) random_transaction();
    settle();
  endtask

  // main sequence
  initial begin
    scoreboard = new();
    work_ticks = 0;
    idle_off   = 1'b0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= i2cm_pkg::CFG_SLAVE_ADDR;
    cfg_wdata  <= 8'd0;
    in_valid   <= 1'b0;
    opcode     <= i2cm_pkg::OP_NONE;
    data_byte  <= 8'd0;
    rnw        <= 1'b0;
    sda_level  <= 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at reset settings: address 0, four ticks per phase
    idle_ticks(2);
    run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_NOISY, 30);
    run_command(i2cm_pkg::OP_ADDR, 8'h00, 1'b0, SDA_LOW, 30);
    run_command(i2cm_pkg::OP_WRITE, 8'h00, 1'b0, SDA_LOW, 30);
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_NOISY, 30);
    settle();

    // top address (upper data bit must be dropped), one tick per phase
    configure(8'hFF, 8'd1);
    // directed: byte extremes, every command, acks and nacks
    run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_NOISY, 30);
    run_command(i2cm_pkg::OP_WRITE, 8'hFF, 1'b1, SDA_LOW, 30);
    run_command(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_HIGH, 30);
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_NOISY, 30);
    run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_NOISY, 30);
    run_command(i2cm_pkg::OP_ADDR, 8'hFF, 1'b1, SDA_LOW, 30);
    run_command(i2cm_pkg::OP_READ_ACK, 8'h00, 1'b0, SDA_HIGH, 30);
    run_command(i2cm_pkg::OP_READ_ACK, 8'hFF, 1'b1, SDA_LOW, 30);
    run_command(i2cm_pkg::OP_READ_NACK, 8'h00, 1'b0, SDA_NOISY, 30);
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_NOISY, 30);
    run_command(i2cm_pkg::OP_ADDR, 8'h00, 1'b1, SDA_HIGH, 30);
    run_command(i2cm_pkg::OP_READ_NACK, 8'h00, 1'b0, SDA_HIGH, 30);
    run_command(i2cm_pkg::OP_WRITE, 8'h5A, 1'b0, SDA_LOW, 30);
    run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_NOISY, 30);
    idle_ticks(2);
    settle();

    run_phase(200);
    // zero phase length acts as one tick
    configure(8'($urandom), 8'd0);
    run_phase(200);
    configure(8'($urandom), 8'($urandom_range(2, 3)));
    run_phase(200);
    // last stretch at full rate, no gaps or stalls
    idle_off = 1'b1;
    configure(8'($urandom), 8'd1);
    run_phase(200);
    repeat (5) @(posedge clk);

    if (scoreboard.pending() > 0)
      scoreboard.report($sformatf("%0d results never arrived", scoreboard.pending()));
    $display("covered %0d results over %0d commands, %0d ending in a nack",
             scoreboard.checked, scoreboard.commands, scoreboard.nacks);
    $display("phase lengths 0, 1, 2-3 and 4; addresses 0, 127 and random");
    if (scoreboard.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
